// ===== rtl/siir_pkg.sv =====
package siir_pkg;

  // sample and coefficient formats
  localparam int LANES        = 4;
  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;
  localparam int COEF_WIDTH   = 32;
  localparam int COEF_FRAC    = 28;
  localparam int CFG_IDX_W    = 3;

  // product of one coefficient and one sample, and the five-term sum
  localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - COEF_FRAC;

  // largest and smallest sample and the identity w value (1.0, saturated if it does not fit)
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] IDENT_ONE =
    (SAMPLE_WIDTH > FRAC_BITS + 1) ? SAMPLE_WIDTH'(64'd1 << FRAC_BITS) : SAMPLE_MAX;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] b0;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_w;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic signed [SAMPLE_WIDTH-1:0] sample_z;
    logic                           restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_w;
    logic signed [SAMPLE_WIDTH-1:0] filtered_x;
    logic signed [SAMPLE_WIDTH-1:0] filtered_y;
    logic signed [SAMPLE_WIDTH-1:0] filtered_z;
  } out_item_t;

  // pipeline control shared by all lanes
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic in_restart;
    logic s1_restart;
  } lane_ctl_t;

endpackage

// ===== rtl/siir_lane.sv =====
module siir_lane #(
  parameter logic signed [siir_pkg::SAMPLE_WIDTH-1:0] Ident = '0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  siir_pkg::coef_t                           coef_i,
  input  siir_pkg::lane_ctl_t                       ctl_i,
  input  logic signed [siir_pkg::SAMPLE_WIDTH-1:0]  sample_i,
  output logic signed [siir_pkg::SAMPLE_WIDTH-1:0]  filtered_o
);
  import siir_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC - 1));
  localparam logic signed [SH_W-1:0]  SH_MAX     = SH_W'(SAMPLE_MAX);
  localparam logic signed [SH_W-1:0]  SH_MIN     = SH_W'(SAMPLE_MIN);

  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [SAMPLE_WIDTH-1:0] x1_eff, x2_eff, y1_eff, y2_eff;
  logic signed [PROD_W-1:0]       p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]        ff_d, ff_q, acc;
  logic signed [SH_W-1:0]         acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_d;

  // stage 1: feedforward terms, input history set to identity on restart
  assign x1_eff = ctl_i.in_restart ? Ident : x1_q;
  assign x2_eff = ctl_i.in_restart ? Ident : x2_q;
  assign p_b0   = coef_i.b0 * sample_i;
  assign p_b1   = coef_i.b1 * x1_eff;
  assign p_b2   = coef_i.b2 * x2_eff;
  assign ff_d   = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2);

  // stage 2: feedback terms, round half up, saturate
  assign y1_eff = ctl_i.s1_restart ? Ident : y1_q;
  assign y2_eff = ctl_i.s1_restart ? Ident : y2_q;
  assign p_a1   = coef_i.a1 * y1_eff;
  assign p_a2   = coef_i.a2 * y2_eff;
  assign acc    = ff_q - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;
  assign acc_sh = SH_W'(acc >>> COEF_FRAC);

  always_comb begin
    if (acc_sh > SH_MAX) begin
      y_d = SAMPLE_MAX;
    end else if (acc_sh < SH_MIN) begin
      y_d = SAMPLE_MIN;
    end else begin
      y_d = acc_sh[SAMPLE_WIDTH-1:0];
    end
  end

  // input history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= Ident;
      x2_q <= Ident;
    end else if (ctl_i.s1_load) begin
      x1_q <= sample_i;
      x2_q <= x1_eff;
    end
  end

  // feedforward sum, payload only
  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_load) begin
      ff_q <= ff_d;
    end
  end

  // output history; the newest entry is also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q <= Ident;
      y2_q <= Ident;
    end else if (ctl_i.s2_load) begin
      y1_q <= y_d;
      y2_q <= y1_eff;
    end
  end

  assign filtered_o = y1_q;

endmodule

// ===== rtl/siir_ctrl.sv =====
module siir_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_restart_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output siir_pkg::lane_ctl_t ctl_o
);
  import siir_pkg::*;

  logic s1_valid_d, s1_valid_q;
  logic s1_restart_q;
  logic out_valid_d, out_valid_q;
  logic out_free, s1_free, s1_load, s2_load;

  // each stage moves on when the one after it is empty or draining
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign s1_load  = in_valid_i && s1_free;
  assign s2_load  = s1_valid_q && out_free;

  always_comb begin
    s1_valid_d  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
    out_valid_d = s2_load ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  // stage valid bits and the restart flag that follows the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_restart_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_load) begin
        s1_restart_q <= in_restart_i;
      end
    end
  end

  assign in_stall_o       = !s1_free;
  assign out_valid_o      = out_valid_q;
  assign ctl_o.s1_load    = s1_load;
  assign ctl_o.s2_load    = s2_load;
  assign ctl_o.in_restart = in_restart_i;
  assign ctl_o.s1_restart = s1_restart_q;

  // a transfer into stage 1 is always held there the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted item not held in stage 1");

  // a full pipeline under output stall keeps both items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && out_valid_q)
    else $error("item dropped under stall");

  // an empty first stage never pushes back on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with stage 1 empty");

  // a stage 2 load produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("stage 2 load lost");

endmodule

// ===== rtl/second_order_iir_four_lane.sv =====
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------
// input    | in_valid_i  | in_stall_o  | in_data_i  (in_item_t)
// output   | out_valid_o | out_stall_i | out_data_o (out_item_t)
// config   | cfg_we_i    | none        | cfg_idx_i, cfg_data_i
//
// one item per cycle unless the output stalls; an item passes ff_q, then
// each lane's combinational feedback multiply, add and saturate into y1_q
// reset: coefficients zero, all histories at the identity quaternion
// an output stall backs up into stage 1; input stalls only when both stages
// hold items and the output stalls
module second_order_iir_four_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  siir_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output siir_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [siir_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [siir_pkg::COEF_WIDTH-1:0]      cfg_data_i
);
  import siir_pkg::*;

  coef_t                          coef_q;
  lane_ctl_t                      ctl;
  logic signed [SAMPLE_WIDTH-1:0] lane_in  [LANES];
  logic signed [SAMPLE_WIDTH-1:0] lane_out [LANES];

  // coefficient registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  coef_q.b0 <= cfg_data_i;
        REG_B1:  coef_q.b1 <= cfg_data_i;
        REG_B2:  coef_q.b2 <= cfg_data_i;
        REG_A1:  coef_q.a1 <= cfg_data_i;
        REG_A2:  coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  siir_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_data_i.restart),
    .in_stall_o   (in_stall_o),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .ctl_o        (ctl)
  );

  // split the quaternion over the lanes, w on lane 0
  assign lane_in[0] = in_data_i.sample_w;
  assign lane_in[1] = in_data_i.sample_x;
  assign lane_in[2] = in_data_i.sample_y;
  assign lane_in[3] = in_data_i.sample_z;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    siir_lane #(
      .Ident ((i == 0) ? IDENT_ONE : '0)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .coef_i     (coef_q),
      .ctl_i      (ctl),
      .sample_i   (lane_in[i]),
      .filtered_o (lane_out[i])
    );
  end

  // merge the lane results into one output item
  assign out_data_o.filtered_w = lane_out[0];
  assign out_data_o.filtered_x = lane_out[1];
  assign out_data_o.filtered_y = lane_out[2];
  assign out_data_o.filtered_z = lane_out[3];

endmodule

// ===== bench/second_order_iir_four_lane_tb.sv =====
`timescale 1ns / 100ps

module second_order_iir_four_lane_tb;
  import siir_pkg::*;

  localparam int COEF_COUNT  = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int END_SLACK   = 8;
  localparam int ITEMS_PER_SET = 100;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = 32'sh1000_0000;
  localparam logic signed [COEF_WIDTH-1:0] COEF_LSB = 32'sh0000_0001;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_WIDTH-1:0] HALF_TIE = 32'sh0800_0000;

  // low-pass coefficient sets in Q4.28, cutoff at 0.1 and 0.25 of the sample rate
  localparam coef_t LOWPASS_SLOW = '{b0: 32'sd18107393, b1: 32'sd36214786,
                                     b2: 32'sd18107393, a1: -32'sd306816492,
                                     a2: 32'sd110810585};
  localparam coef_t LOWPASS_FAST = '{b0: 32'sd78622920, b1: 32'sd157245840,
                                     b2: 32'sd78622920, a1: 32'sd0,
                                     a2: 32'sd46056250};

  // tracks coefficients and lane histories, holds filtered quaternions still owed
  class quat_lowpass_board;
    logic signed [COEF_WIDTH-1:0]   coefs    [COEF_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] in_hist1 [LANES];
    logic signed [SAMPLE_WIDTH-1:0] in_hist2 [LANES];
    logic signed [SAMPLE_WIDTH-1:0] out_hist1[LANES];
    logic signed [SAMPLE_WIDTH-1:0] out_hist2[LANES];
    out_item_t pending_filtered[$];
    int mismatches;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      mismatches = 0;
      set_identity();
    endfunction

    function void set_identity();
      for (int l = 0; l < LANES; l++) begin
        in_hist1[l]  = (l == 0) ? IDENT_ONE : '0;
        in_hist2[l]  = in_hist1[l];
        out_hist1[l] = in_hist1[l];
        out_hist2[l] = in_hist1[l];
      end
    endfunction

    // indexes past the coefficient bank are dropped
    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_WIDTH-1:0] val);
      if (idx < COEF_COUNT) coefs[idx] = val;
    endfunction

    // biquad per lane: exact five-term sum, round half up, saturate
    function void note_sample(in_item_t it);
      logic signed [SAMPLE_WIDTH-1:0] x[LANES];
      logic signed [SAMPLE_WIDTH-1:0] y[LANES];
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] round_half;
      out_item_t res;
      round_half = 1 <<< (COEF_FRAC - 1);
      x[0] = it.sample_w;
      x[1] = it.sample_x;
      x[2] = it.sample_y;
      x[3] = it.sample_z;
      if (it.restart) set_identity();
      for (int l = 0; l < LANES; l++) begin
        acc = coefs[REG_B0] * x[l] + coefs[REG_B1] * in_hist1[l]
            + coefs[REG_B2] * in_hist2[l] - coefs[REG_A1] * out_hist1[l]
            - coefs[REG_A2] * out_hist2[l] + round_half;
        acc = acc >>> COEF_FRAC;
        if (acc > SAMPLE_MAX) y[l] = SAMPLE_MAX;
        else if (acc < SAMPLE_MIN) y[l] = SAMPLE_MIN;
        else y[l] = acc[SAMPLE_WIDTH-1:0];
        in_hist2[l]  = in_hist1[l];
        in_hist1[l]  = x[l];
        out_hist2[l] = out_hist1[l];
        out_hist1[l] = y[l];
      end
      res = '{y[0], y[1], y[2], y[3]};
      pending_filtered.push_back(res);
    endfunction

    function void check_filtered(out_item_t got);
      out_item_t want;
      logic signed [SAMPLE_WIDTH-1:0] w_lane[LANES];
      logic signed [SAMPLE_WIDTH-1:0] g_lane[LANES];
      string lane_name[LANES];
      lane_name = '{"w", "x", "y", "z"};
      if (pending_filtered.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_filtered.pop_front();
      w_lane = '{want.filtered_w, want.filtered_x, want.filtered_y, want.filtered_z};
      g_lane = '{got.filtered_w, got.filtered_x, got.filtered_y, got.filtered_z};
      for (int l = 0; l < LANES; l++) begin
        if (g_lane[l] !== w_lane[l]) begin
          $display("%0t: filtered_%s expected %0d actual %0d",
                   $time, lane_name[l], w_lane[l], g_lane[l]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  in_item_t                in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_item_t               out_data_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [COEF_WIDTH-1:0]   cfg_data_i = '0;

  quat_lowpass_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  second_order_iir_four_lane uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_filtered(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one sample transfer, with an optional random gap before it
  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_sample(it);
  endtask

  // wait until every filtered result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_filtered.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_coef(idx, val);
  endtask

  // full coefficient bank plus one write to an unused index
  task automatic load_coefs(input coef_t c);
    write_reg(REG_B0, c.b0);
    write_reg(REG_B1, c.b1);
    write_reg(REG_B2, c.b2);
    write_reg(REG_A1, c.a1);
    write_reg(REG_A2, c.a2);
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, COEF_COUNT)), $urandom());
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic signed [SAMPLE_WIDTH-1:0] w,
                                         logic signed [SAMPLE_WIDTH-1:0] x,
                                         logic signed [SAMPLE_WIDTH-1:0] y,
                                         logic signed [SAMPLE_WIDTH-1:0] z,
                                         logic restart);
    in_item_t it;
    it = '{w, x, y, z, restart};
    return it;
  endfunction

  // calm samples mostly stay near unit scale, otherwise wide values and extremes
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(bit calm);
    logic signed [SAMPLE_WIDTH-1:0] v;
    if (calm && $urandom_range(9) != 0) begin
      v = $urandom_range(2 ** 22);
      return v - (2 ** 21);
    end
    case ($urandom_range(9))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = IDENT_ONE;
      3: v = -IDENT_ONE;
      4: v = $urandom_range(1) ? '0 : '1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic in_item_t random_item(bit calm);
    return make_item(pick_sample(calm), pick_sample(calm), pick_sample(calm),
                     pick_sample(calm), $urandom_range(99) < 3);
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] pick_extreme(int phase);
    case (phase)
      0: return COEF_MAX;
      1: return COEF_MIN;
      default: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
    endcase
  endfunction

  initial begin
    coef_t bank;
    bit calm;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients still at reset: everything filters to zero
    push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, '1, 32'sd1, 1'b0));
    drain();

    // pass-through with unit b0
    load_coefs('{b0: COEF_ONE, b1: '0, b2: '0, a1: '0, a2: '0});
    push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, '0, '1, 1'b0));
    push_item(make_item(IDENT_ONE, -IDENT_ONE, 32'sd12345, -32'sd98765, 1'b1));
    push_item(make_item('0, '0, '0, '0, 1'b0));
    drain();

    // history taps: restart puts the identity into both histories
    load_coefs('{b0: '0, b1: COEF_ONE, b2: '0, a1: '0, a2: COEF_ONE});
    push_item(make_item('0, '0, '0, '0, 1'b1));
    push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, '1, 32'sd1, 1'b0));
    push_item(make_item(32'sd7, -32'sd7, IDENT_ONE, '0, 1'b0));
    drain();

    // saturation both ways with the largest coefficients
    load_coefs('{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MAX, a2: COEF_MAX});
    push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, '0, 32'sd1, 1'b0));
    drain();

    // exact halves round toward plus infinity
    load_coefs('{b0: COEF_LSB, b1: '0, b2: '0, a1: '0, a2: '0});
    push_item(make_item(HALF_TIE, -HALF_TIE, 3 * HALF_TIE, -3 * HALF_TIE, 1'b0));
    push_item(make_item(HALF_TIE - 1, -HALF_TIE - 1, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    drain();

    // most negative coefficients
    load_coefs('{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN});
    push_item(make_item(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
    push_item(make_item(SAMPLE_MAX, SAMPLE_MAX, '1, 32'sd1, 1'b0));
    drain();

    // random part: three idling profiles, four coefficient banks each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 81;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int set = 0; set < 4; set++) begin
        drain();
        calm = 1'b1;
        case (set)
          0: bank = LOWPASS_SLOW;
          1: begin
            bank = '{b0: $urandom(), b1: $urandom(), b2: $urandom(),
                     a1: $urandom(), a2: $urandom()};
            calm = 1'b0;
          end
          2: begin
            bank = '{b0: pick_extreme(phase), b1: pick_extreme(phase),
                     b2: pick_extreme(phase), a1: pick_extreme(phase),
                     a2: pick_extreme(phase)};
            calm = 1'b0;
          end
          default: bank = LOWPASS_FAST;
        endcase
        load_coefs(bank);
        repeat (ITEMS_PER_SET) push_item(random_item(calm));
      end
    end

    drain();
    repeat (END_SLACK) @(posedge clk_i);
    if (board.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
